// File: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/pcsp_pkg.sv
package pcsp_pkg;

    localparam logic [2:0] ST_PARSING     = 3'd0;
    localparam logic [2:0] ST_BAD_SIG     = 3'd1;
    localparam logic [2:0] ST_BAD_HEADER  = 3'd2;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd3;
    localparam logic [2:0] ST_IEND        = 3'd4;

    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
    } t_byte_req;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [2:0]  status;
        logic [31:0] image_width;
        logic [31:0] image_height;
        logic [7:0]  pixel_depth;
        logic [7:0]  color_mode;
        logic [7:0]  interlace_method;
        logic [31:0] gamma_value;
        logic        gamma_present;
        logic [7:0]  render_intent;
        logic        srgb_present;
    } t_result;

endpackage

// File: hdl/pcsp_in_if.sv
interface pcsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

// File: hdl/pcsp_out_if.sv
interface pcsp_out_if;
    logic        valid;
    logic        ready;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [2:0]  status;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic [7:0]  pixel_depth;
    logic [7:0]  color_mode;
    logic [7:0]  interlace_method;
    logic [31:0] gamma_value;
    logic        gamma_present;
    logic [7:0]  render_intent;
    logic        srgb_present;

    modport source (
        output valid, input ready,
        output payload_valid, output payload_byte, output status,
        output image_width, output image_height, output pixel_depth,
        output color_mode, output interlace_method, output gamma_value,
        output gamma_present, output render_intent, output srgb_present
    );
    modport sink (
        input valid, output ready,
        input payload_valid, input payload_byte, input status,
        input image_width, input image_height, input pixel_depth,
        input color_mode, input interlace_method, input gamma_value,
        input gamma_present, input render_intent, input srgb_present
    );
endinterface

// File: hdl/png_chunk_stream_parser.sv
// registers: a byte taken sits in the input register and its result is loaded into the result
//   register when the parser takes the byte, which waits while the result side stalls
// throughput: one byte per cycle while the result side does not stall; the parser updates its phase per byte
// reset: synchronous active-low i_rst_n clears the phase to signature check, all counters,
//   status and captured header, gamma and srgb fields to zero, and empties both registers
module png_chunk_stream_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pcsp_in_if.sink     i_in,
    pcsp_out_if.source  o_out
);

    pcsp_pkg::t_byte_req req;
    pcsp_pkg::t_result   res;
    logic                take;
    logic                out_valid;

    pcsp_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (take),
        .o_req   (req)
    );

    pcsp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .o_take      (take),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .o_res       (res)
    );

    assign o_out.valid            = out_valid;
    assign o_out.payload_valid    = res.payload_valid;
    assign o_out.payload_byte     = res.payload_byte;
    assign o_out.status           = res.status;
    assign o_out.image_width      = res.image_width;
    assign o_out.image_height     = res.image_height;
    assign o_out.pixel_depth      = res.pixel_depth;
    assign o_out.color_mode       = res.color_mode;
    assign o_out.interlace_method = res.interlace_method;
    assign o_out.gamma_value      = res.gamma_value;
    assign o_out.gamma_present    = res.gamma_present;
    assign o_out.render_intent    = res.render_intent;
    assign o_out.srgb_present     = res.srgb_present;

endmodule

// File: hdl/pcsp_in_stage.sv
`include "assert_macros.svh"

module pcsp_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    pcsp_in_if.sink             i_in,
    input  logic                i_take,
    output pcsp_pkg::t_byte_req o_req
);

    logic       r_valid;
    logic [7:0] r_byte;

    // slot frees up in the same cycle the parser takes the held byte
    assign i_in.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_byte <= i_in.data_byte;
        end
    end

    assign o_req.valid     = r_valid;
    assign o_req.data_byte = r_byte;

    `ASSERT_NEXT(a_held_byte_kept, r_valid && !i_take, r_valid && r_byte == $past(r_byte), "held byte lost before parser took it")

endmodule

// File: hdl/pcsp_parser.sv
`include "assert_macros.svh"

module pcsp_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pcsp_pkg::t_byte_req i_req,
    output logic                o_take,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output pcsp_pkg::t_result   o_res
);

    typedef enum logic [3:0] {
        PH_SIG   = 4'd0,
        PH_HDR   = 4'd1,
        PH_CLEN  = 4'd2,
        PH_CTYPE = 4'd3,
        PH_IDAT  = 4'd4,
        PH_GAMA  = 4'd5,
        PH_SRGB  = 4'd6,
        PH_SKIP  = 4'd7,
        PH_CRC   = 4'd8,
        PH_DONE  = 4'd9
    } t_phase;

    localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
    localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;
    localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
    localparam logic [31:0] TYPE_GAMA = 32'h6741_4D41;
    localparam logic [31:0] TYPE_SRGB = 32'h7352_4742;
    localparam logic [31:0] IHDR_LEN  = 32'd13;
    localparam logic [7:0]  NEEDED_DEPTH = 8'd8;
    localparam logic [7:0]  RGB_COLOR    = 8'd2;
    localparam logic [7:0]  RGBA_COLOR   = 8'd6;

    // byte positions inside the ihdr chunk, counted from its length field
    localparam logic [31:0] HI_LEN    = 32'd3;
    localparam logic [31:0] HI_TYPE   = 32'd7;
    localparam logic [31:0] HI_WIDTH  = 32'd11;
    localparam logic [31:0] HI_HEIGHT = 32'd15;
    localparam logic [31:0] HI_DEPTH  = 32'd16;
    localparam logic [31:0] HI_COLOR  = 32'd17;
    localparam logic [31:0] HI_COMP   = 32'd18;
    localparam logic [31:0] HI_FILTER = 32'd19;
    localparam logic [31:0] HI_ILACE  = 32'd20;
    localparam logic [31:0] HI_LAST   = 32'd24;
    localparam logic [31:0] LAST_SIG  = 32'd7;
    localparam logic [31:0] LAST_WORD = 32'd3;

    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] v;
        unique case (idx)
            3'd0: v = 8'h89;
            3'd1: v = 8'h50;
            3'd2: v = 8'h4E;
            3'd3: v = 8'h47;
            3'd4: v = 8'h0D;
            3'd5: v = 8'h0A;
            3'd6: v = 8'h1A;
            3'd7: v = 8'h0A;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    t_phase            r_phase, n_phase;
    logic [31:0]       r_byte_count, n_byte_count;
    logic [31:0]       r_chunk_length, n_chunk_length;
    logic [31:0]       r_chunk_type, n_chunk_type;
    logic [31:0]       r_field_shift, n_field_shift;
    logic [2:0]        r_status, n_status;
    logic [31:0]       r_width, n_width;
    logic [31:0]       r_height, n_height;
    logic [7:0]        r_depth, n_depth;
    logic [7:0]        r_color, n_color;
    logic [7:0]        r_interlace, n_interlace;
    logic [31:0]       r_gamma, n_gamma;
    logic              r_gamma_flag, n_gamma_flag;
    logic [7:0]        r_intent, n_intent;
    logic              r_intent_flag, n_intent_flag;
    logic              r_out_valid;
    pcsp_pkg::t_result r_res, n_res;

    logic [7:0]  b;
    logic [31:0] count_inc;
    logic        payload_last;
    logic        pvalid;
    t_phase      body_phase;

    assign o_take = i_req.valid && (!r_out_valid || i_out_ready);

    always_comb begin
        n_phase        = r_phase;
        n_byte_count   = r_byte_count;
        n_chunk_length = r_chunk_length;
        n_chunk_type   = r_chunk_type;
        n_field_shift  = r_field_shift;
        n_status       = r_status;
        n_width        = r_width;
        n_height       = r_height;
        n_depth        = r_depth;
        n_color        = r_color;
        n_interlace    = r_interlace;
        n_gamma        = r_gamma;
        n_gamma_flag   = r_gamma_flag;
        n_intent       = r_intent;
        n_intent_flag  = r_intent_flag;
        pvalid         = 1'b0;
        body_phase     = PH_SKIP;

        b            = i_req.data_byte;
        count_inc    = r_byte_count + 32'd1;
        payload_last = (count_inc == r_chunk_length);

        if (r_phase != PH_DONE) begin
            n_field_shift = {r_field_shift[23:0], b};
        end

        unique case (r_phase)
            PH_SIG: begin
                if (b != sig_byte(r_byte_count[2:0])) begin
                    n_status = pcsp_pkg::ST_BAD_SIG;
                    n_phase  = PH_DONE;
                end else if (r_byte_count >= LAST_SIG) begin
                    n_phase      = PH_HDR;
                    n_byte_count = '0;
                end else begin
                    n_byte_count = count_inc;
                end
            end
            PH_HDR: begin
                n_byte_count = count_inc;
                priority if (r_byte_count == HI_LEN) begin
                    if (n_field_shift != IHDR_LEN) begin
                        n_status     = pcsp_pkg::ST_BAD_HEADER;
                        n_phase      = PH_DONE;
                        n_byte_count = r_byte_count;
                    end
                end else if (r_byte_count == HI_TYPE) begin
                    if (n_field_shift != TYPE_IHDR) begin
                        n_status     = pcsp_pkg::ST_BAD_HEADER;
                        n_phase      = PH_DONE;
                        n_byte_count = r_byte_count;
                    end
                end else if (r_byte_count == HI_WIDTH) begin
                    n_width = n_field_shift;
                end else if (r_byte_count == HI_HEIGHT) begin
                    n_height = n_field_shift;
                end else if (r_byte_count == HI_DEPTH) begin
                    n_depth = b;
                end else if (r_byte_count == HI_COLOR) begin
                    n_color = b;
                end else if (r_byte_count == HI_COMP || r_byte_count == HI_FILTER) begin
                    if (b != 8'd0) begin
                        n_status     = pcsp_pkg::ST_BAD_HEADER;
                        n_phase      = PH_DONE;
                        n_byte_count = r_byte_count;
                    end
                end else if (r_byte_count == HI_ILACE) begin
                    n_interlace = b;
                    if (r_depth != NEEDED_DEPTH ||
                        (r_color != RGB_COLOR && r_color != RGBA_COLOR)) begin
                        n_status     = pcsp_pkg::ST_UNSUPPORTED;
                        n_phase      = PH_DONE;
                        n_byte_count = r_byte_count;
                    end
                end else if (r_byte_count == HI_LAST) begin
                    n_phase      = PH_CLEN;
                    n_byte_count = '0;
                end else begin
                    n_byte_count = count_inc;
                end
            end
            PH_CLEN: begin
                if (r_byte_count >= LAST_WORD) begin
                    n_chunk_length = n_field_shift;
                    n_phase        = PH_CTYPE;
                    n_byte_count   = '0;
                end else begin
                    n_byte_count = count_inc;
                end
            end
            PH_CTYPE: begin
                if (r_byte_count >= LAST_WORD) begin
                    n_chunk_type = n_field_shift;
                    priority if (n_field_shift == TYPE_IDAT) begin
                        body_phase = PH_IDAT;
                    end else if (n_field_shift == TYPE_GAMA) begin
                        body_phase = PH_GAMA;
                    end else if (n_field_shift == TYPE_SRGB) begin
                        body_phase = PH_SRGB;
                    end else begin
                        body_phase = PH_SKIP;
                    end
                    if (n_field_shift == TYPE_IEND) begin
                        // iend stops the walk without reading its body or crc
                        n_status = pcsp_pkg::ST_IEND;
                        n_phase  = PH_DONE;
                    end else begin
                        n_phase      = (r_chunk_length == 32'd0) ? PH_CRC : body_phase;
                        n_byte_count = '0;
                    end
                end else begin
                    n_byte_count = count_inc;
                end
            end
            PH_IDAT, PH_GAMA, PH_SRGB, PH_SKIP: begin
                if (r_phase == PH_IDAT) begin
                    pvalid = 1'b1;
                end
                if (r_phase == PH_GAMA && r_byte_count == LAST_WORD) begin
                    n_gamma      = n_field_shift;
                    n_gamma_flag = 1'b1;
                end
                if (r_phase == PH_SRGB && r_byte_count == 32'd0) begin
                    n_intent      = b;
                    n_intent_flag = 1'b1;
                end
                if (payload_last) begin
                    n_phase      = PH_CRC;
                    n_byte_count = '0;
                end else begin
                    n_byte_count = count_inc;
                end
            end
            PH_CRC: begin
                if (r_byte_count >= LAST_WORD) begin
                    n_phase      = PH_CLEN;
                    n_byte_count = '0;
                end else begin
                    n_byte_count = count_inc;
                end
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase

        n_res.payload_valid    = pvalid;
        n_res.payload_byte     = pvalid ? b : 8'd0;
        n_res.status           = n_status;
        n_res.image_width      = n_width;
        n_res.image_height     = n_height;
        n_res.pixel_depth      = n_depth;
        n_res.color_mode       = n_color;
        n_res.interlace_method = n_interlace;
        n_res.gamma_value      = n_gamma;
        n_res.gamma_present    = n_gamma_flag;
        n_res.render_intent    = n_intent;
        n_res.srgb_present     = n_intent_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_SIG;
            r_byte_count   <= '0;
            r_chunk_length <= '0;
            r_chunk_type   <= '0;
            r_field_shift  <= '0;
            r_status       <= pcsp_pkg::ST_PARSING;
            r_width        <= '0;
            r_height       <= '0;
            r_depth        <= '0;
            r_color        <= '0;
            r_interlace    <= '0;
            r_gamma        <= '0;
            r_gamma_flag   <= 1'b0;
            r_intent       <= '0;
            r_intent_flag  <= 1'b0;
            r_out_valid    <= 1'b0;
        end else if (o_take) begin
            r_phase        <= n_phase;
            r_byte_count   <= n_byte_count;
            r_chunk_length <= n_chunk_length;
            r_chunk_type   <= n_chunk_type;
            r_field_shift  <= n_field_shift;
            r_status       <= n_status;
            r_width        <= n_width;
            r_height       <= n_height;
            r_depth        <= n_depth;
            r_color        <= n_color;
            r_interlace    <= n_interlace;
            r_gamma        <= n_gamma;
            r_gamma_flag   <= n_gamma_flag;
            r_intent       <= n_intent;
            r_intent_flag  <= n_intent_flag;
            r_out_valid    <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

    `ASSERT_IMPLY(a_done_iff_status, 1'b1, (r_phase == PH_DONE) == (r_status != pcsp_pkg::ST_PARSING), "done phase and status disagree")
    `ASSERT_NEXT(a_status_sticky, r_status != pcsp_pkg::ST_PARSING, r_status == $past(r_status), "error or end status changed")
    `ASSERT_IMPLY(a_body_in_range, r_phase == PH_IDAT || r_phase == PH_GAMA || r_phase == PH_SRGB || r_phase == PH_SKIP, r_byte_count < r_chunk_length, "chunk body count ran past its length")
    `ASSERT_IMPLY(a_payload_only_parsing, r_out_valid && r_res.payload_valid, r_res.status == pcsp_pkg::ST_PARSING && r_chunk_type == TYPE_IDAT, "payload byte outside an idat chunk")

endmodule

// File: tb/pcsp_checker.sv
`timescale 1ns / 1ps

module pcsp_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    pcsp_in_if   i_bytes,
    pcsp_out_if  i_results,
    output int   o_errors,
    output int   o_pending
);

    localparam logic [63:0] PNG_SIG    = 64'h89504E470D0A1A0A;
    localparam logic [31:0] TYPE_IHDR  = "IHDR";
    localparam logic [31:0] TYPE_IEND  = "IEND";
    localparam logic [31:0] TYPE_IDAT  = "IDAT";
    localparam logic [31:0] TYPE_GAMA  = "gAMA";
    localparam logic [31:0] TYPE_SRGB  = "sRGB";
    localparam logic [31:0] IHDR_LEN   = 32'd13;
    localparam logic [7:0]  DEPTH_8    = 8'd8;
    localparam logic [7:0]  COLOR_RGB  = 8'd2;
    localparam logic [7:0]  COLOR_RGBA = 8'd6;
    localparam int          MAX_PRINTED = 40;

    typedef enum logic [3:0] {
        P_SIG, P_HDR, P_LEN, P_TYPE, P_IDAT, P_GAMA, P_SRGB, P_SKIP, P_CRC, P_DONE
    } t_parse_phase;

    // parser state, starts at its reset values
    t_parse_phase ph          = P_SIG;
    logic [31:0]  pos         = '0;
    logic [31:0]  clen        = '0;
    logic [31:0]  ctype       = '0;
    logic [31:0]  shreg       = '0;
    logic [2:0]   status      = pcsp_pkg::ST_PARSING;
    logic [31:0]  width       = '0;
    logic [31:0]  height      = '0;
    logic [7:0]   depth       = '0;
    logic [7:0]   color       = '0;
    logic [7:0]   interlace   = '0;
    logic [31:0]  gamma       = '0;
    logic         gamma_seen  = 1'b0;
    logic [7:0]   intent      = '0;
    logic         intent_seen = 1'b0;

    pcsp_pkg::t_result expected_q[$];
    int                error_count = 0;
    int                pending_count = 0;
    int                result_idx = 0;

    assign o_errors  = error_count;
    assign o_pending = pending_count;

    task automatic report_error(input string msg);
        if (error_count < MAX_PRINTED) begin
            $display("ERROR result %0d: %s", result_idx, msg);
        end
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_error($sformatf("%s got %0h expected %0h", name, got, want));
        end
    endtask

    function automatic void halt(input logic [2:0] code);
        status = code;
        ph     = P_DONE;
    endfunction

    function automatic void enter_phase(input t_parse_phase next);
        ph  = next;
        pos = '0;
    endfunction

    // one byte of chunk body, crc follows the last one
    function automatic void payload_step();
        if (pos + 32'd1 == clen) begin
            enter_phase(P_CRC);
        end else begin
            pos = pos + 32'd1;
        end
    endfunction

    function automatic pcsp_pkg::t_result parse_byte(input logic [7:0] b);
        pcsp_pkg::t_result r;
        r = '0;
        if (ph != P_DONE) begin
            shreg = {shreg[23:0], b};
        end
        case (ph)
            P_SIG: begin
                if (b != PNG_SIG[63 - 8 * pos[2:0] -: 8]) begin
                    halt(pcsp_pkg::ST_BAD_SIG);
                end else if (pos >= 7) begin
                    enter_phase(P_HDR);
                end else begin
                    pos = pos + 32'd1;
                end
            end
            P_HDR: begin
                // offsets within the ihdr chunk, length field first
                case (pos)
                    3: if (shreg != IHDR_LEN) halt(pcsp_pkg::ST_BAD_HEADER);
                    7: if (shreg != TYPE_IHDR) halt(pcsp_pkg::ST_BAD_HEADER);
                    11: width = shreg;
                    15: height = shreg;
                    16: depth = b;
                    17: color = b;
                    18, 19: if (b != 8'd0) halt(pcsp_pkg::ST_BAD_HEADER);
                    20: begin
                        interlace = b;
                        if (depth != DEPTH_8 || (color != COLOR_RGB && color != COLOR_RGBA)) begin
                            halt(pcsp_pkg::ST_UNSUPPORTED);
                        end
                    end
                    default: ;
                endcase
                if (ph == P_HDR && pos == 24) begin
                    enter_phase(P_LEN);
                end else begin
                    pos = pos + 32'd1;
                end
            end
            P_LEN: begin
                if (pos >= 3) begin
                    clen = shreg;
                    enter_phase(P_TYPE);
                end else begin
                    pos = pos + 32'd1;
                end
            end
            P_TYPE: begin
                if (pos >= 3) begin
                    ctype = shreg;
                    if (ctype == TYPE_IEND) begin
                        halt(pcsp_pkg::ST_IEND);
                    end else if (clen == '0) begin
                        enter_phase(P_CRC);
                    end else if (ctype == TYPE_IDAT) begin
                        enter_phase(P_IDAT);
                    end else if (ctype == TYPE_GAMA) begin
                        enter_phase(P_GAMA);
                    end else if (ctype == TYPE_SRGB) begin
                        enter_phase(P_SRGB);
                    end else begin
                        enter_phase(P_SKIP);
                    end
                end else begin
                    pos = pos + 32'd1;
                end
            end
            P_IDAT: begin
                r.payload_valid = 1'b1;
                r.payload_byte  = b;
                payload_step();
            end
            P_GAMA: begin
                if (pos == 3) begin
                    gamma      = shreg;
                    gamma_seen = 1'b1;
                end
                payload_step();
            end
            P_SRGB: begin
                if (pos == 0) begin
                    intent      = b;
                    intent_seen = 1'b1;
                end
                payload_step();
            end
            P_SKIP: payload_step();
            P_CRC: begin
                if (pos >= 3) begin
                    enter_phase(P_LEN);
                end else begin
                    pos = pos + 32'd1;
                end
            end
            default: ph = P_DONE;
        endcase
        r.status           = status;
        r.image_width      = width;
        r.image_height     = height;
        r.pixel_depth      = depth;
        r.color_mode       = color;
        r.interlace_method = interlace;
        r.gamma_value      = gamma_seen ? gamma : '0;
        r.gamma_present    = gamma_seen;
        r.render_intent    = intent_seen ? intent : '0;
        r.srgb_present     = intent_seen;
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        pcsp_pkg::t_result want;
        if (i_rst_n) begin
            // results leave before the byte taken at this edge can show up
            if (i_results.valid && i_results.ready) begin
                if (expected_q.size() == 0) begin
                    report_error("result with no byte pending");
                end else begin
                    want = expected_q.pop_front();
                    check_field("payload_valid", 32'(i_results.payload_valid),
                                32'(want.payload_valid));
                    check_field("payload_byte", 32'(i_results.payload_byte),
                                32'(want.payload_byte));
                    check_field("status", 32'(i_results.status), 32'(want.status));
                    check_field("image_width", i_results.image_width, want.image_width);
                    check_field("image_height", i_results.image_height, want.image_height);
                    check_field("pixel_depth", 32'(i_results.pixel_depth),
                                32'(want.pixel_depth));
                    check_field("color_mode", 32'(i_results.color_mode),
                                32'(want.color_mode));
                    check_field("interlace_method", 32'(i_results.interlace_method),
                                32'(want.interlace_method));
                    check_field("gamma_value", i_results.gamma_value, want.gamma_value);
                    check_field("gamma_present", 32'(i_results.gamma_present),
                                32'(want.gamma_present));
                    check_field("render_intent", 32'(i_results.render_intent),
                                32'(want.render_intent));
                    check_field("srgb_present", 32'(i_results.srgb_present),
                                32'(want.srgb_present));
                end
                result_idx++;
            end
            if (i_bytes.valid && i_bytes.ready) begin
                expected_q.push_back(parse_byte(i_bytes.data_byte));
            end
            pending_count <= expected_q.size();
        end
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam logic [63:0] PNG_SIG   = 64'h89504E470D0A1A0A;
    localparam logic [31:0] TYPE_IHDR = "IHDR";
    localparam logic [31:0] TYPE_IEND = "IEND";
    localparam logic [31:0] TYPE_IDAT = "IDAT";
    localparam logic [31:0] TYPE_GAMA = "gAMA";
    localparam logic [31:0] TYPE_SRGB = "sRGB";
    localparam logic [31:0] IHDR_LEN  = 32'd13;

    // how the file goes wrong, if at all
    localparam int STREAM_GOOD       = 0;
    localparam int STREAM_BAD_SIG    = 1;
    localparam int STREAM_BAD_LEN    = 2;
    localparam int STREAM_BAD_TYPE   = 3;
    localparam int STREAM_BAD_COMP   = 4;
    localparam int STREAM_BAD_FILTER = 5;
    localparam int STREAM_BAD_FORMAT = 6;
    localparam int STREAM_NO_IEND    = 7;

    localparam int CHUNK_BYTES    = 880;
    localparam int QUIET_TAIL     = 100;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 1000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic [7:0] png_bytes[$];
    bit         calm = 1'b1;
    int         stall_left = 0;
    int         idle_cycles = 0;
    int         errors;
    int         pending;

    pcsp_in_if  in_ch();
    pcsp_out_if out_ch();

    png_chunk_stream_parser i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    pcsp_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_bytes   (in_ch),
        .i_results (out_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_word(input logic [31:0] w);
        png_bytes.push_back(w[31:24]);
        png_bytes.push_back(w[23:16]);
        png_bytes.push_back(w[15:8]);
        png_bytes.push_back(w[7:0]);
    endtask

    task automatic push_chunk(input logic [31:0] ctype, input int unsigned len);
        push_word(len);
        push_word(ctype);
        repeat (len) png_bytes.push_back(rand_byte());
        push_word($urandom);
    endtask

    // result side stalls in bursts except in calm stretches
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left    <= 0;
            out_ch.ready  <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            out_ch.ready  <= (stall_left == 1);
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left    <= $urandom_range(1, 5);
            out_ch.ready  <= 1'b0;
        end else begin
            out_ch.ready  <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        int          kind;
        int          bad_pos;
        int unsigned len;
        logic [31:0] ctype;
        logic [31:0] word;
        logic [7:0]  b;
        logic [7:0]  depth;
        logic [7:0]  color;

        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= 8'h00;

        kind    = ($urandom_range(0, 2) != 0) ? STREAM_GOOD : int'($urandom_range(1, 7));
        bad_pos = int'($urandom_range(0, 7));

        // signature
        for (int k = 0; k < 8; k++) begin
            b = PNG_SIG[63 - 8 * k -: 8];
            if (kind == STREAM_BAD_SIG && k == bad_pos) b = b ^ 8'($urandom_range(1, 255));
            png_bytes.push_back(b);
        end

        // ihdr
        word = IHDR_LEN;
        if (kind == STREAM_BAD_LEN) begin
            word = $urandom;
            if (word == IHDR_LEN) word = ~word;
        end
        push_word(word);
        ctype = TYPE_IHDR;
        if (kind == STREAM_BAD_TYPE) ctype = ctype ^ (32'h1 << $urandom_range(0, 31));
        push_word(ctype);
        repeat (2) begin
            case ($urandom_range(0, 3))
                0: push_word(32'h0000_0000);
                1: push_word(32'hFFFF_FFFF);
                default: push_word($urandom);
            endcase
        end
        depth = 8'd8;
        color = ($urandom_range(0, 1) != 0) ? 8'd6 : 8'd2;
        if (kind == STREAM_BAD_FORMAT) begin
            if ($urandom_range(0, 1) != 0) begin
                depth = rand_byte();
                if (depth == 8'd8) depth = 8'd16;
            end else begin
                color = rand_byte();
                if (color == 8'd2 || color == 8'd6) color = 8'd3;
            end
        end
        png_bytes.push_back(depth);
        png_bytes.push_back(color);
        png_bytes.push_back((kind == STREAM_BAD_COMP) ? 8'($urandom_range(1, 255)) : 8'd0);
        png_bytes.push_back((kind == STREAM_BAD_FILTER) ? 8'($urandom_range(1, 255)) : 8'd0);
        png_bytes.push_back(rand_byte());
        push_word($urandom);

        // chunk walk
        while (png_bytes.size() < CHUNK_BYTES) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 120)
                                                      : $urandom_range(1, 24);
                    push_chunk(TYPE_IDAT, len);
                end
                4: begin
                    case ($urandom_range(0, 3))
                        0: len = $urandom_range(0, 3);
                        1: len = $urandom_range(5, 9);
                        default: len = 4;
                    endcase
                    push_chunk(TYPE_GAMA, len);
                end
                5: begin
                    case ($urandom_range(0, 3))
                        0: len = 0;
                        1: len = $urandom_range(2, 5);
                        default: len = 1;
                    endcase
                    push_chunk(TYPE_SRGB, len);
                end
                6: begin
                    ctype = $urandom;
                    if (ctype == TYPE_IEND) ctype = TYPE_IHDR;
                    push_chunk(ctype, $urandom_range(0, 16));
                end
                7: begin
                    // one bit away from a known type
                    case ($urandom_range(0, 3))
                        0: ctype = TYPE_IDAT;
                        1: ctype = TYPE_GAMA;
                        2: ctype = TYPE_SRGB;
                        default: ctype = TYPE_IEND;
                    endcase
                    push_chunk(ctype ^ (32'h1 << $urandom_range(0, 31)), $urandom_range(0, 8));
                end
                8: begin
                    case ($urandom_range(0, 3))
                        0: ctype = TYPE_IDAT;
                        1: ctype = TYPE_GAMA;
                        2: ctype = TYPE_SRGB;
                        default: ctype = $urandom;
                    endcase
                    if (ctype == TYPE_IEND) ctype = TYPE_IDAT;
                    push_chunk(ctype, 0);
                end
                default: push_chunk(TYPE_IHDR, $urandom_range(0, 13));
            endcase
        end

        // end of stream, then bytes that must be ignored
        if (kind != STREAM_NO_IEND) begin
            push_word(($urandom_range(0, 3) == 0) ? $urandom : 32'd0);
            push_word(TYPE_IEND);
            repeat ($urandom_range(4, 12)) png_bytes.push_back(rand_byte());
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (png_bytes[k]) begin
            calm = ((k / 64) % 3 == 0) || (k + QUIET_TAIL >= png_bytes.size());
            if (!calm && $urandom_range(0, 5) == 0) begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
            in_ch.valid     <= 1'b1;
            in_ch.data_byte <= png_bytes[k];
            do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        end
        in_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/pcsp_pkg.sv
hdl/pcsp_in_if.sv
hdl/pcsp_out_if.sv
hdl/pcsp_in_stage.sv
hdl/pcsp_parser.sv
hdl/png_chunk_stream_parser.sv
tb/pcsp_checker.sv
tb/tb_top.sv
